>>> hdl/pts_pkg.sv
// Package for the process table scheduler: sizes, codes, state encodings and
// the divider handshake types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;
  localparam int unsigned TableSize = 16;
  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned CntW = $clog2(TableSize + 1);
  localparam logic [16:0] StrideNum = 17'd100000;
  localparam logic [6:0] FullShare = 7'd100;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_END   = 2'd1,
    REQ_PICK  = 2'd2,
    REQ_RATE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NOTFND  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_REFUSED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    POL_FIRST  = 3'd0,
    POL_OLDEST = 3'd1,
    POL_NEWEST = 3'd2,
    POL_RR     = 3'd3,
    POL_STRIDE = 3'd4
  } policy_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SUB,
    S_DIV_RATE,
    S_SPREAD_Q,
    S_SPREAD_DIV,
    S_SPREAD_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> hdl/pts_if.sv
// Valid/ready channel interfaces for events, results and policy writes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface pts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] proc_id;
  logic [6:0]  rate_percent;
  modport source (output valid, req_type, proc_id, rate_percent, input ready);
  modport sink (input valid, req_type, proc_id, rate_percent, output ready);
endinterface

interface pts_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] chosen_id;
  logic [2:0]  status;
  modport source (output valid, chosen_id, status, input ready);
  modport sink (input valid, chosen_id, status, output ready);
endinterface

interface pts_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hdl/pts_div.sv
// Restoring bit-serial divider, one quotient bit per cycle, 17 by 7 bits.
// Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pts_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pts_pkg::div_req_t req_i,
  output pts_pkg::div_rsp_t     rsp_o
);
  logic [16:0] quot_q, quot_d;
  logic [7:0]  rem_q, rem_d;
  logic [6:0]  dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [7:0]  trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[6:0], quot_q[16]};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[15:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without run");
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 5'd0 || $past(req_i.start) == 1'b0)
    else $error("divider count inconsistent");
  a_busy_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 5'd0) else $error("divider busy with zero count");
`endif
endmodule
`default_nettype wire

>>> hdl/process_table_scheduler_core.sv
// Process table scheduler with a sequencer that walks the table one entry
// per cycle and a shared serial divider. Depends on pts_pkg, pts_if, pts_div.
//
// Each event is accepted, then the table is scanned one entry per cycle,
// followed by a decide state and a completion state, after which the start,
// end or pick result is registered. A stride pick adds a second pass over
// the table to rebase the pass values. A granted rate request runs the
// 17-step serial divider for its own stride. When entries without a request
// remain, it then divides the free share by their number, divides again for
// their stride unless the share per entry is zero, and writes it in a sweep
// over the table. The result waits in an output register, and the next event
// is taken no earlier than the cycle after the result beat.
`timescale 1ns / 1ps
`default_nettype none
module process_table_scheduler_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pts_req_if.sink   req_i,
  pts_rsp_if.source rsp_o,
  pts_cfg_if.sink   cfg_i
);
  localparam int unsigned N = pts_pkg::TableSize;
  localparam int unsigned IW = pts_pkg::IdxW;
  localparam int unsigned CW = pts_pkg::CntW;

  logic [N-1:0]  valid_q;
  logic [N-1:0]  hasshr_q;
  logic [15:0]   owner_q [N];
  logic [31:0]   arrival_q [N];
  logic [17:0]   pass_q [N];
  logic [16:0]   stride_q [N];
  logic [6:0]    share_q [N];

  logic [31:0]   arr_cnt_q;
  logic [6:0]    alloc_q;
  logic [CW-1:0] live_q, shared_q;
  logic [IW:0]   last_q;
  logic [2:0]    policy_q;

  pts_pkg::state_e state_q, state_d;
  logic [1:0]    kind_q;
  logic [15:0]   id_q;
  logic [6:0]    rate_q;
  logic [CW-1:0] idx_q;
  logic          found_q;
  logic [IW-1:0] best_q;
  logic [17:0]   low_q;
  logic [IW-1:0] start_q;
  logic [16:0]   spread_q;
  logic          out_v_q;
  logic [15:0]   out_id_q;
  logic [2:0]    out_st_q;

  pts_pkg::div_req_t div_req;
  pts_pkg::div_rsp_t div_rsp;

  pts_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  logic [IW-1:0] cur;
  logic          scan_last;
  logic [6:0]    freeshare;
  logic [CW-1:0] procs;
  logic          hit;

  assign scan_last = (idx_q == CW'(N - 1));
  assign freeshare = (alloc_q <= pts_pkg::FullShare) ? pts_pkg::FullShare - alloc_q : 7'd0;
  assign procs     = live_q - shared_q;
  assign cur       = (kind_q == pts_pkg::REQ_PICK && policy_q == pts_pkg::POL_RR &&
                      state_q == pts_pkg::S_SCAN) ? start_q + idx_q[IW-1:0] : idx_q[IW-1:0];

  always_comb begin
    hit = 1'b0;
    unique case (kind_q)
      pts_pkg::REQ_START: hit = !valid_q[cur];
      pts_pkg::REQ_END, pts_pkg::REQ_RATE: hit = valid_q[cur] && owner_q[cur] == id_q;
      default: begin
        unique case (policy_q)
          pts_pkg::POL_FIRST, pts_pkg::POL_RR: hit = valid_q[cur];
          pts_pkg::POL_OLDEST: hit = valid_q[cur] &&
                                 (!found_q || arrival_q[cur] < arrival_q[best_q]);
          pts_pkg::POL_NEWEST: hit = valid_q[cur] &&
                                 (!found_q || arrival_q[cur] > arrival_q[best_q]);
          pts_pkg::POL_STRIDE: hit = valid_q[cur] &&
                                 (!found_q || pass_q[cur] < pass_q[best_q]);
          default: hit = 1'b0;
        endcase
      end
    endcase
  end

  logic first_only;
  assign first_only = kind_q != pts_pkg::REQ_PICK || policy_q == pts_pkg::POL_FIRST ||
                      policy_q == pts_pkg::POL_RR;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::S_IDLE: if (req_i.valid && !out_v_q) state_d = pts_pkg::S_SCAN;
      pts_pkg::S_SCAN: if (scan_last || (hit && first_only)) state_d = pts_pkg::S_DECIDE;
      pts_pkg::S_DECIDE: begin
        if (kind_q == pts_pkg::REQ_PICK && policy_q == pts_pkg::POL_STRIDE && found_q)
          state_d = pts_pkg::S_SUB;
        else if (kind_q == pts_pkg::REQ_RATE && found_q && rate_q >= 7'd1 &&
                 rate_q <= pts_pkg::FullShare &&
                 {1'b0, share_q[best_q]} + {1'b0, freeshare} >= {1'b0, rate_q})
          state_d = pts_pkg::S_DIV_RATE;
        else state_d = pts_pkg::S_DONE;
      end
      pts_pkg::S_SUB: if (scan_last) state_d = pts_pkg::S_DONE;
      pts_pkg::S_DIV_RATE: if (div_rsp.done) state_d = pts_pkg::S_SPREAD_Q;
      pts_pkg::S_SPREAD_Q: begin
        if (live_q <= shared_q) state_d = pts_pkg::S_DONE;
        else if (div_rsp.done)
          state_d = (div_rsp.quot[6:0] == 7'd0) ? pts_pkg::S_DONE : pts_pkg::S_SPREAD_DIV;
      end
      pts_pkg::S_SPREAD_DIV: if (div_rsp.done) state_d = pts_pkg::S_SPREAD_WR;
      pts_pkg::S_SPREAD_WR: if (scan_last) state_d = pts_pkg::S_DONE;
      pts_pkg::S_DONE: state_d = pts_pkg::S_IDLE;
      default: state_d = pts_pkg::S_IDLE;
    endcase
  end

  // Divider launches: one for each divide state, the free-share divide from within S_SPREAD_Q.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = pts_pkg::StrideNum;
    div_req.divisor  = rate_q;
    if (state_q == pts_pkg::S_DECIDE && state_d == pts_pkg::S_DIV_RATE) begin
      div_req.start = 1'b1;
    end else if (state_q == pts_pkg::S_SPREAD_Q && !div_rsp.busy && !div_rsp.done &&
                 live_q > shared_q) begin
      div_req.start    = 1'b1;
      div_req.dividend = {10'd0, freeshare};
      div_req.divisor  = {{(7 - CW){1'b0}}, procs};
    end else if (state_q == pts_pkg::S_SPREAD_Q && state_d == pts_pkg::S_SPREAD_DIV) begin
      div_req.start   = 1'b1;
      div_req.divisor = div_rsp.quot[6:0];
    end
  end

  assign req_i.ready = (state_q == pts_pkg::S_IDLE) && !out_v_q;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_v_q;
  assign rsp_o.chosen_id = out_id_q;
  assign rsp_o.status = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pts_pkg::S_IDLE;
      valid_q  <= '0;
      hasshr_q <= '0;
      for (int i = 0; i < N; i++) begin
        pass_q[i]   <= '0;
        stride_q[i] <= '0;
        share_q[i]  <= '0;
      end
      arr_cnt_q <= '0;
      alloc_q   <= '0;
      live_q    <= '0;
      shared_q  <= '0;
      last_q    <= (IW + 1)'(N);
      policy_q  <= pts_pkg::POL_NEWEST;
      out_v_q   <= 1'b0;
      idx_q     <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) policy_q <= cfg_i.data;
      if (out_v_q && rsp_o.ready) out_v_q <= 1'b0;
      unique case (state_q)
        pts_pkg::S_IDLE: begin
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        pts_pkg::S_SCAN: begin
          if (hit) found_q <= 1'b1;
          idx_q <= (scan_last || (hit && first_only)) ? '0 : idx_q + CW'(1);
        end
        pts_pkg::S_DECIDE: begin
          if (kind_q == pts_pkg::REQ_START && found_q) begin
            valid_q[best_q]  <= 1'b1;
            hasshr_q[best_q] <= 1'b0;
            pass_q[best_q]   <= '0;
            stride_q[best_q] <= '0;
            share_q[best_q]  <= '0;
            arr_cnt_q <= arr_cnt_q + 32'd1;
            live_q    <= live_q + CW'(1);
          end
          if (kind_q == pts_pkg::REQ_END && found_q) begin
            valid_q[best_q]  <= 1'b0;
            live_q <= live_q - CW'(1);
            alloc_q <= (alloc_q >= share_q[best_q]) ? alloc_q - share_q[best_q] : 7'd0;
            if (hasshr_q[best_q] && shared_q != '0) shared_q <= shared_q - CW'(1);
            share_q[best_q]  <= '0;
            hasshr_q[best_q] <= 1'b0;
          end
          if (kind_q == pts_pkg::REQ_PICK && policy_q == pts_pkg::POL_RR && found_q)
            last_q <= {1'b0, best_q};
        end
        pts_pkg::S_SUB: begin
          if (valid_q[cur]) begin
            if (cur == best_q) pass_q[cur] <= pass_q[cur] - low_q + {1'b0, stride_q[cur]};
            else pass_q[cur] <= pass_q[cur] - low_q;
          end
          idx_q <= scan_last ? '0 : idx_q + CW'(1);
        end
        pts_pkg::S_DIV_RATE: begin
          if (div_rsp.done) begin
            alloc_q          <= alloc_q - share_q[best_q] + rate_q;
            share_q[best_q]  <= rate_q;
            stride_q[best_q] <= div_rsp.quot;
            if (!hasshr_q[best_q]) begin
              hasshr_q[best_q] <= 1'b1;
              shared_q <= shared_q + CW'(1);
            end
          end
        end
        pts_pkg::S_SPREAD_WR: begin
          if (valid_q[cur] && !hasshr_q[cur]) stride_q[cur] <= spread_q;
          idx_q <= scan_last ? '0 : idx_q + CW'(1);
        end
        default: ;
      endcase
      if (state_q == pts_pkg::S_DONE) out_v_q <= 1'b1;
    end
  end

  // Free share is not read in S_DIV_RATE; the spread divide is launched from
  // S_SPREAD_Q instead, after the grant has updated the allocation.
  logic [15:0] chosen;
  assign chosen = (kind_q == pts_pkg::REQ_PICK && found_q) ? owner_q[best_q] : 16'd0;

  always_ff @(posedge clk_i) begin
    if (state_q == pts_pkg::S_IDLE) begin
      kind_q  <= req_i.req_type;
      id_q    <= req_i.proc_id;
      rate_q  <= req_i.rate_percent;
      start_q <= (last_q >= (IW + 1)'(N)) ? '0 : last_q[IW-1:0] + IW'(1);
    end
    if (state_q == pts_pkg::S_SCAN && hit) begin
      best_q <= cur;
      low_q  <= pass_q[cur];
    end
    if (state_q == pts_pkg::S_DECIDE && kind_q == pts_pkg::REQ_START && found_q) begin
      owner_q[best_q]   <= id_q;
      arrival_q[best_q] <= arr_cnt_q;
    end
    if (div_rsp.done && state_q == pts_pkg::S_SPREAD_DIV) spread_q <= div_rsp.quot;
    if (state_q == pts_pkg::S_DONE) begin
      out_id_q <= chosen;
      priority if (kind_q == pts_pkg::REQ_START && !found_q) out_st_q <= pts_pkg::ST_FULL;
      else if (kind_q == pts_pkg::REQ_RATE &&
               (rate_q == 7'd0 || rate_q > pts_pkg::FullShare)) out_st_q <= pts_pkg::ST_RANGE;
      else if ((kind_q == pts_pkg::REQ_END || kind_q == pts_pkg::REQ_RATE) && !found_q)
        out_st_q <= pts_pkg::ST_NOTFND;
      else if (kind_q == pts_pkg::REQ_RATE && share_q[best_q] != rate_q)
        out_st_q <= pts_pkg::ST_REFUSED;
      else out_st_q <= pts_pkg::ST_OK;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != pts_pkg::S_IDLE |-> !req_i.ready) else $error("accepted while busy");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q == CW'($countones(valid_q))) else $error("live count mismatch");
  a_shared_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shared_q <= live_q) else $error("shared count above live count");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pts_pkg::S_DONE |=> out_v_q) else $error("result not raised");
`endif
endmodule
`default_nettype wire
